// ===== src/didct_pkg.sv =====
// Package for the dequantizing 8x8 IDCT core: quantization tables, transform
// constants and the sequencer-to-datapath control struct. No dependencies.
`timescale 1ns / 1ps
package didct_pkg;

	localparam logic [7:0] PosLast = 8'd191;

	localparam logic [11:0] KC1 = 12'd2841;
	localparam logic [11:0] KC2 = 12'd2676;
	localparam logic [11:0] KC3 = 12'd2408;
	localparam logic [11:0] KC5 = 12'd1609;
	localparam logic [11:0] KC6 = 12'd1108;
	localparam logic [11:0] KC7 = 12'd565;
	localparam logic [11:0] KCR = 12'd181;

	function automatic logic [6:0] luma_q(input logic [5:0] i);
		logic [6:0] t [64];
		t = '{7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
			7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
			7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
			7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
			7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
			7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
			7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
			7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99};
		return t[i];
	endfunction

	function automatic logic [6:0] chroma_q(input logic [5:0] i);
		logic [6:0] t [64];
		t = '{7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
			7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
			7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
			7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
			7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
			7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
			7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
			7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99};
		return t[i];
	endfunction

	// start command and pass direction for the shared 1D transform unit
	typedef struct packed {
		logic       go;
		logic       col;
	} xf_ctl_t;

	function automatic logic [31:0] asr32(input logic [31:0] v, input logic [3:0] n);
		return 32'($signed(v) >>> n);
	endfunction

endpackage

// ===== src/didct_xform.sv =====
// Shared 1D Chen-Wang transform unit: one 32x12 multiplier, stepped by a
// micro-op counter. Depends on didct_pkg.
`timescale 1ns / 1ps
module didct_xform (
	input  logic                 clk,
	input  logic                 arst_n,
	input  didct_pkg::xf_ctl_t   ctl,
	input  logic [15:0]          e_in [8],
	output logic [15:0]          e_out [8],
	output logic                 done
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} st_t;

	st_t         st_q;
	logic [4:0]  op_q;
	logic        col_q;
	logic [31:0] e_q [8];
	logic [31:0] x_q [9];
	logic [31:0] ma_q;
	logic [11:0] mb_q;
	logic [31:0] p_q;
	logic [15:0] o_q [8];
	logic        ac_zero;
	logic [31:0] r32;
	logic [3:0]  sh;
	logic [3:0]  fs;
	logic [31:0] prod;

	assign r32 = col_q ? 32'd4 : 32'd0;
	assign sh = col_q ? 4'd3 : 4'd0;
	assign fs = col_q ? 4'd14 : 4'd8;
	assign prod = 32'(ma_q * {20'd0, mb_q});
	assign ac_zero = (e_q[1] | e_q[2] | e_q[3] | e_q[4] | e_q[5] | e_q[6] | e_q[7]) == 32'd0;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			e_out[k] = o_q[k];
		end
	end
	assign done = (st_q == ST_DONE);

	// each op loads multiplier operands, consumes an earlier product, or combines terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			op_q <= '0;
			col_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (ctl.go) begin
						col_q <= ctl.col;
						for (int k = 0; k < 8; k++) begin
							e_q[k] <= {{16{e_in[k][15]}}, e_in[k]};
						end
						op_q <= '0;
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					op_q <= op_q + 5'd1;
					p_q <= prod;
					case (op_q)
						5'd0: begin
							if (ac_zero) begin
								for (int k = 0; k < 8; k++) begin
									o_q[k] <= col_q ?
										16'(didct_pkg::asr32(e_q[0] + 32'd32, 4'd6)) :
										16'(e_q[0] << 3);
								end
								st_q <= ST_DONE;
							end
							x_q[0] <= col_q ? (e_q[0] << 8) + 32'd8192 : (e_q[0] << 11) + 32'd128;
							x_q[1] <= col_q ? e_q[4] << 8 : e_q[4] << 11;
							ma_q <= e_q[1] + e_q[7]; mb_q <= didct_pkg::KC7;
						end
						5'd1: begin ma_q <= e_q[1]; mb_q <= didct_pkg::KC1 - didct_pkg::KC7; end
						5'd2: begin x_q[8] <= p_q + r32;
							ma_q <= e_q[7]; mb_q <= didct_pkg::KC1 + didct_pkg::KC7; end
						5'd3: begin x_q[4] <= didct_pkg::asr32(x_q[8] + p_q, sh);
							ma_q <= e_q[5] + e_q[3]; mb_q <= didct_pkg::KC3; end
						5'd4: begin x_q[5] <= didct_pkg::asr32(x_q[8] - p_q, sh);
							ma_q <= e_q[5]; mb_q <= didct_pkg::KC3 - didct_pkg::KC5; end
						5'd5: begin x_q[8] <= p_q + r32;
							ma_q <= e_q[3]; mb_q <= didct_pkg::KC3 + didct_pkg::KC5; end
						5'd6: begin x_q[6] <= didct_pkg::asr32(x_q[8] - p_q, sh);
							ma_q <= e_q[2] + e_q[6]; mb_q <= didct_pkg::KC6; end
						5'd7: begin x_q[7] <= didct_pkg::asr32(x_q[8] - p_q, sh);
							ma_q <= e_q[6]; mb_q <= didct_pkg::KC2 + didct_pkg::KC6; end
						5'd8: begin x_q[3] <= p_q + r32;
							ma_q <= e_q[2]; mb_q <= didct_pkg::KC2 - didct_pkg::KC6; end
						5'd9: begin x_q[2] <= didct_pkg::asr32(x_q[3] - p_q, sh);
							x_q[8] <= x_q[0] + x_q[1]; x_q[0] <= x_q[0] - x_q[1]; end
						5'd10: begin x_q[3] <= didct_pkg::asr32(x_q[3] + p_q, sh);
							x_q[1] <= x_q[4] + x_q[6]; x_q[4] <= x_q[4] - x_q[6];
							x_q[6] <= x_q[5] + x_q[7]; x_q[5] <= x_q[5] - x_q[7]; end
						5'd11: begin
							x_q[7] <= x_q[8] + x_q[3]; x_q[8] <= x_q[8] - x_q[3];
							x_q[3] <= x_q[0] + x_q[2]; x_q[0] <= x_q[0] - x_q[2];
							ma_q <= x_q[4] + x_q[5]; mb_q <= didct_pkg::KCR;
						end
						5'd12: begin ma_q <= x_q[4] - x_q[5]; mb_q <= didct_pkg::KCR; end
						5'd13: x_q[2] <= didct_pkg::asr32(p_q + 32'd128, 4'd8);
						5'd14: x_q[4] <= didct_pkg::asr32(p_q + 32'd128, 4'd8);
						default: begin
							o_q[0] <= 16'(didct_pkg::asr32(x_q[7] + x_q[1], fs));
							o_q[1] <= 16'(didct_pkg::asr32(x_q[3] + x_q[2], fs));
							o_q[2] <= 16'(didct_pkg::asr32(x_q[0] + x_q[4], fs));
							o_q[3] <= 16'(didct_pkg::asr32(x_q[8] + x_q[6], fs));
							o_q[4] <= 16'(didct_pkg::asr32(x_q[8] - x_q[6], fs));
							o_q[5] <= 16'(didct_pkg::asr32(x_q[0] - x_q[4], fs));
							o_q[6] <= 16'(didct_pkg::asr32(x_q[3] - x_q[2], fs));
							o_q[7] <= 16'(didct_pkg::asr32(x_q[7] - x_q[1], fs));
							st_q <= ST_DONE;
						end
					endcase
				end
				ST_DONE: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.go |-> st_q == ST_IDLE) else $error("transform started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_op_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RUN |-> op_q <= 5'd15) else $error("op counter overran");
`endif

endmodule

// ===== src/dequant_idct_8x8_three_plane_core.sv =====
// Coefficients are taken one per cycle while busy is low; after a block's 64th,
// 16 one-dimensional passes each gather, transform and write back a line (the
// transform is shorter when the line's AC terms are all zero), then 64 samples
// follow one per cycle. The core is busy from the 64th item to the last sample.
// Reset: arst_n clears position and sequencer, not the block store.
// The receiver cannot stall; results appear for one cycle with valid high.
`timescale 1ns / 1ps
module dequant_idct_8x8_three_plane_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] coefficient,
	output logic               valid,
	output logic signed [15:0] sample,
	output logic [1:0]         plane,
	output logic               last
);

	typedef enum logic [2:0] {S_LOAD, S_RD, S_XF, S_WR, S_OUT} st_t;

	st_t              st_q;
	logic [7:0]       pos_q;
	logic [1:0]       plane_q;
	logic [15:0]      mem_q [64];
	logic [15:0]      rd_q;
	logic [15:0]      row_q [8];
	logic [3:0]       line_q;
	logic [3:0]       cnt_q;
	logic [6:0]       oidx_q;
	logic             launch_q;
	didct_pkg::xf_ctl_t ctl;
	logic [15:0]      e_in [8];
	logic [15:0]      e_out [8];
	logic             xf_done;
	logic [5:0]       idx;
	logic [6:0]       q;
	logic [22:0]      prod;
	logic [5:0]       line_addr;
	logic             mem_we;
	logic [5:0]       mem_wa;
	logic [15:0]      mem_wd;
	logic [5:0]       mem_ra;

	assign idx = pos_q[5:0];
	assign q = (pos_q[7:6] == 2'd0) ? didct_pkg::luma_q(idx) : didct_pkg::chroma_q(idx);
	assign prod = 23'(coefficient * $signed({1'b0, q}));
	assign busy = (st_q != S_LOAD);
	assign ctl.go = (st_q == S_XF) && launch_q;
	assign ctl.col = line_q[3];

	// row passes walk along a row, column passes down a column
	assign line_addr = line_q[3] ? {cnt_q[2:0], line_q[2:0]} : {line_q[2:0], cnt_q[2:0]};

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			e_in[k] = row_q[k];
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = line_addr;
		mem_wd = e_out[cnt_q[2:0]];
		mem_ra = line_addr;
		case (st_q)
			S_LOAD: begin
				mem_we = start;
				mem_wa = idx;
				mem_wd = prod[15:0];
			end
			S_WR: mem_we = 1'b1;
			S_OUT: mem_ra = oidx_q[5:0];
			default: mem_we = 1'b0;
		endcase
	end

	// block store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		rd_q <= mem_q[mem_ra];
	end

	didct_xform u_xf (.clk(clk), .arst_n(arst_n), .ctl(ctl), .e_in(e_in),
		.e_out(e_out), .done(xf_done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LOAD;
			pos_q <= '0;
			plane_q <= '0;
			line_q <= '0;
			cnt_q <= '0;
			oidx_q <= '0;
			launch_q <= 1'b0;
			for (int k = 0; k < 8; k++) row_q[k] <= '0;
			valid <= 1'b0;
			sample <= '0;
			plane <= '0;
			last <= 1'b0;
		end else begin
			valid <= (st_q == S_OUT) && (oidx_q != 7'd0);
			case (st_q)
				S_LOAD: begin
					if (start) begin
						pos_q <= (pos_q == didct_pkg::PosLast) ? 8'd0 : pos_q + 8'd1;
						if (idx == 6'd63) begin
							plane_q <= pos_q[7:6];
							line_q <= '0;
							cnt_q <= '0;
							st_q <= S_RD;
						end
					end
				end
				S_RD: begin
					// read data is registered, so it trails its address into the next cycle
					if (cnt_q != 4'd0) row_q[cnt_q[2:0] - 3'd1] <= rd_q;
					if (cnt_q == 4'd8) begin
						cnt_q <= '0;
						launch_q <= 1'b1;
						st_q <= S_XF;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_XF: begin
					if (launch_q) begin
						launch_q <= 1'b0;
					end else if (xf_done) begin
						st_q <= S_WR;
					end
				end
				S_WR: begin
					if (cnt_q == 4'd7) begin
						cnt_q <= '0;
						if (line_q == 4'd15) begin
							oidx_q <= '0;
							st_q <= S_OUT;
						end else begin
							line_q <= line_q + 4'd1;
							st_q <= S_RD;
						end
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_OUT: begin
					if (oidx_q != 7'd0) begin
						sample <= rd_q + ((plane_q == 2'd0) ? 16'd128 : 16'd0);
						plane <= plane_q;
						last <= (oidx_q == 7'd64);
					end
					oidx_q <= oidx_q + 7'd1;
					if (oidx_q == 7'd64) st_q <= S_LOAD;
				end
				default: st_q <= S_LOAD;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= didct_pkg::PosLast) else $error("position out of range");
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last && valid |=> !valid) else $error("sample after last");
	a_no_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(st_q) == S_OUT) else $error("stray strobe");
`endif

endmodule

// ===== verif/idct_checker.sv =====
// Checker for the dequantizing 8x8 IDCT core: predicts the samples of each
// block from the accepted coefficients and compares them. Uses didct_pkg.
`timescale 1ns / 1ps
module idct_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] coefficient,
	input  logic               valid,
	input  logic signed [15:0] sample,
	input  logic [1:0]         plane,
	input  logic               last,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [15:0] smp;
		logic [1:0]  pln;
		logic        lst;
	} pixel_t;

	pixel_t      pixel_q[$];
	logic [15:0] coef_mem [64];
	logic [7:0]  seq_pos;

	function automatic logic [31:0] sra(input logic [31:0] v, input int n);
		return 32'($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] sext(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// one 1D pass in place over eight entries of the store
	task automatic pass_1d(input int base, input int stride, input logic col);
		logic [31:0] e [8];
		logic [31:0] x0, x1, x2, x3, x4, x5, x6, x7, x8, r, v;
		int sh, fs;
		for (int k = 0; k < 8; k++) e[k] = sext(coef_mem[base + k * stride]);
		if ((e[1] | e[2] | e[3] | e[4] | e[5] | e[6] | e[7]) == 0) begin
			v = col ? sra(e[0] + 32, 6) : (e[0] << 3);
			for (int k = 0; k < 8; k++) coef_mem[base + k * stride] = v[15:0];
			return;
		end
		r = col ? 4 : 0;
		sh = col ? 3 : 0;
		fs = col ? 14 : 8;
		x0 = col ? (e[0] << 8) + 32'd8192 : (e[0] << 11) + 32'd128;
		x1 = col ? e[4] << 8 : e[4] << 11;
		x2 = e[6]; x3 = e[2]; x4 = e[1]; x5 = e[7]; x6 = e[5]; x7 = e[3];
		x8 = 32'(didct_pkg::KC7) * (x4 + x5) + r;
		x4 = sra(x8 + 32'(didct_pkg::KC1 - didct_pkg::KC7) * x4, sh);
		x5 = sra(x8 - 32'(didct_pkg::KC1 + didct_pkg::KC7) * x5, sh);
		x8 = 32'(didct_pkg::KC3) * (x6 + x7) + r;
		x6 = sra(x8 - 32'(didct_pkg::KC3 - didct_pkg::KC5) * x6, sh);
		x7 = sra(x8 - 32'(didct_pkg::KC3 + didct_pkg::KC5) * x7, sh);
		x8 = x0 + x1;
		x0 = x0 - x1;
		x1 = 32'(didct_pkg::KC6) * (x3 + x2) + r;
		x2 = sra(x1 - 32'(didct_pkg::KC2 + didct_pkg::KC6) * x2, sh);
		x3 = sra(x1 + 32'(didct_pkg::KC2 - didct_pkg::KC6) * x3, sh);
		x1 = x4 + x6;
		x4 = x4 - x6;
		x6 = x5 + x7;
		x5 = x5 - x7;
		x7 = x8 + x3;
		x8 = x8 - x3;
		x3 = x0 + x2;
		x0 = x0 - x2;
		x2 = sra(32'(didct_pkg::KCR) * (x4 + x5) + 128, 8);
		x4 = sra(32'(didct_pkg::KCR) * (x4 - x5) + 128, 8);
		e[0] = sra(x7 + x1, fs);
		e[1] = sra(x3 + x2, fs);
		e[2] = sra(x0 + x4, fs);
		e[3] = sra(x8 + x6, fs);
		e[4] = sra(x8 - x6, fs);
		e[5] = sra(x0 - x4, fs);
		e[6] = sra(x3 - x2, fs);
		e[7] = sra(x7 - x1, fs);
		for (int k = 0; k < 8; k++) coef_mem[base + k * stride] = e[k][15:0];
	endtask

	task automatic dequant_coef(input logic [15:0] c);
		logic [1:0]  pl;
		logic [5:0]  idx;
		logic [31:0] q, prod;
		pixel_t      p;
		pl = seq_pos[7:6];
		idx = seq_pos[5:0];
		q = (pl == 2'd0) ? 32'(didct_pkg::luma_q(idx)) : 32'(didct_pkg::chroma_q(idx));
		prod = sext(c) * q;
		coef_mem[idx] = prod[15:0];
		seq_pos = (seq_pos == didct_pkg::PosLast) ? 8'd0 : seq_pos + 8'd1;
		if (idx != 6'd63) return;
		for (int i = 0; i < 8; i++) pass_1d(i * 8, 1, 1'b0);
		for (int i = 0; i < 8; i++) pass_1d(i, 8, 1'b1);
		for (int i = 0; i < 64; i++) begin
			p.smp = (pl == 2'd0) ? coef_mem[i] + 16'd128 : coef_mem[i];
			p.pln = pl;
			p.lst = (i == 63);
			pixel_q.push_back(p);
		end
	endtask

	initial begin
		errors = 0;
		seq_pos = '0;
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n) begin
			if (valid) begin
				if (pixel_q.size() == 0) begin
					errors++;
					$display("%0t: sample %0d with none expected", $time, sample);
				end else begin
					want = pixel_q.pop_front();
					if (want.smp !== sample || want.pln !== plane || want.lst !== last) begin
						errors++;
						$display("%0t: expected sample %0d plane %0d last %0b, got %0d %0d %0b",
							$time, $signed(want.smp), want.pln, want.lst,
							sample, plane, last);
					end
				end
			end
			if (start && !busy) dequant_coef(coefficient);
		end
		pending = pixel_q.size();
	end
endmodule

// ===== verif/tb.sv =====
// Testbench top for dequant_idct_8x8_three_plane_core: feeds coefficients and
// gives the verdict. Depends on the core and idct_checker.
`timescale 1ns / 1ps
module tb;
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [15:0] coefficient = '0;
	logic               valid;
	logic signed [15:0] sample;
	logic [1:0]         plane;
	logic               last;
	int                 errors;
	int                 pending;
	logic               calm = 1'b0;

	always #4 clk = ~clk;

	dequant_idct_8x8_three_plane_core u_dut (.*);
	idct_checker u_chk (.*);

	// hold start until the item is taken; busy is stable at the falling edge
	task automatic send_coef(input logic [15:0] c);
		if (!calm) begin
			while ($urandom_range(99) < 20) begin
				start <= 1'b0;
				@(negedge clk);
			end
		end
		start <= 1'b1;
		coefficient <= c;
		while (busy) @(negedge clk);
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_coef(input int slot);
		case ($urandom_range(9))
			0: return 16'($urandom);
			1: return 16'h8000 | 16'($urandom_range(3));
			2, 3, 4: return (slot < 10) ? 16'($signed($urandom_range(80)) - 40) : 16'd0;
			5: return 16'($signed($urandom_range(8)) - 4);
			6: return 16'h7FFF - 16'($urandom_range(3));
			default: return 16'd0;
		endcase
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// luma block: extremes and a dc-only row; cb all zero; cr alternating max and min
		for (int i = 0; i < 64; i++)
			send_coef(i == 0 ? 16'h7FFF : i == 1 ? 16'h8000 : i == 9 ? 16'hFFFF :
				i < 16 && i[0] ? 16'h5555 : i < 16 ? 16'hAAAA : i == 16 ? 16'd3 : 16'd0);
		for (int i = 0; i < 64; i++) send_coef(16'd0);
		for (int i = 0; i < 64; i++) send_coef(i[0] ? 16'h7FFF : 16'h8000);
		for (int b = 0; b < 3; b++) begin
			calm = (b == 1);
			for (int i = 0; i < 64; i++) send_coef(rand_coef(i));
		end
		calm = 1'b0;
		for (int i = 0; i < 36; i++) send_coef(rand_coef($urandom_range(63)));
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("** dequant_idct_8x8_three_plane_core: PASSED **");
		else
			$display("** dequant_idct_8x8_three_plane_core: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("** dequant_idct_8x8_three_plane_core: FAILED **");
		$finish;
	end
endmodule
